### hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; clk and rst_n are taken from the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define BQ_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, reset masked
`define BQ_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/bq_pkg.sv
// types and constants for the biquad high-pass filter
// no dependencies; imported by every module of the block
package bq_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 32;
    localparam int PX_W      = SAMPLE_W + COEF_W;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    // reset coefficients, 90 Hz high-pass at 16 kHz
    localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd1047239728;
    localparam logic signed [COEF_W-1:0] B1_RESET = -32'sd2094480530;
    localparam logic signed [COEF_W-1:0] B2_RESET = 32'sd1047239728;
    localparam logic signed [COEF_W-1:0] A1_RESET = -32'sd2093826622;
    localparam logic signed [COEF_W-1:0] A2_RESET = 32'sd1021392615;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       restart;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } out_item_t;

    // step control for the serial multipliers
    typedef struct packed {
        logic clr;
        logic en;
        logic mbit;
        logic mlast;
        logic negate;
    } mul_ctrl_t;

endpackage

### hdl/bq_serial_mul.sv
// serial-parallel multiplier: coefficient in parallel, multiplier one bit a cycle lsb first
// depends on bq_pkg
module bq_serial_mul
    import bq_pkg::*;
#(
    parameter int LOW_W = 56
)
(
    input  logic                    clk,
    input  mul_ctrl_t               ctrl,
    input  logic signed [COEF_W-1:0] mcand,
    output logic signed [COEF_W:0]  acc,
    output logic [LOW_W-1:0]        low
);

    localparam int SUM_W = COEF_W + 2;

    logic signed [COEF_W:0]  acc_reg;
    logic signed [COEF_W:0]  acc_next;
    logic [LOW_W-1:0]        low_reg;
    logic [LOW_W-1:0]        low_next;
    logic signed [SUM_W-1:0] sum;

    // add or subtract the coefficient; the sign bit of the multiplier weighs negative
    always_comb
    begin
        priority if (!ctrl.mbit)
        begin
            sum = SUM_W'(acc_reg);
        end
        else if (ctrl.mlast ^ ctrl.negate)
        begin
            sum = SUM_W'(acc_reg) - SUM_W'(mcand);
        end
        else
        begin
            sum = SUM_W'(acc_reg) + SUM_W'(mcand);
        end
    end

    // shift one bit of product into the low word each step
    always_comb
    begin
        acc_next = acc_reg;
        low_next = low_reg;
        priority if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.en)
        begin
            acc_next = sum[SUM_W-1:1];
            low_next = {sum[0], low_reg[LOW_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        low_reg <= low_next;
    end

    assign acc = acc_reg;
    assign low = low_reg;

endmodule

### hdl/bq_round_sat.sv
// output stage: round to nearest with ties away from zero, then clip to 16 bits
// depends on bq_pkg
module bq_round_sat
    import bq_pkg::*;
#(
    parameter int STATE_W = 56,
    parameter int FRAC_W  = 30
)
(
    input  logic signed [STATE_W-1:0] y,
    output out_item_t                 result
);

    localparam int RW = STATE_W + 1;
    localparam logic signed [RW-1:0] HALF      = RW'(65'd1 << (FRAC_W - 1));
    localparam logic signed [RW-1:0] HALF_LESS = HALF - RW'(1);
    localparam logic signed [RW-1:0] OUT_MAX   = RW'((1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [RW-1:0] OUT_MIN   = RW'(-(1 <<< (SAMPLE_W - 1)));

    logic signed [RW-1:0] biased;
    logic signed [RW-1:0] rounded;

    // negative values take half less one lsb so the floor rounds away from zero
    always_comb
    begin
        biased  = RW'(y) + (y[STATE_W-1] ? HALF_LESS : HALF);
        rounded = biased >>> FRAC_W;
        priority if (rounded > OUT_MAX)
        begin
            result.sample_out = OUT_MAX[SAMPLE_W-1:0];
            result.clipped    = 1'b1;
        end
        else if (rounded < OUT_MIN)
        begin
            result.sample_out = OUT_MIN[SAMPLE_W-1:0];
            result.clipped    = 1'b1;
        end
        else
        begin
            result.sample_out = rounded[SAMPLE_W-1:0];
            result.clipped    = 1'b0;
        end
    end

endmodule

### hdl/biquad_highpass_filter.sv
// biquad high-pass filter, transposed direct form ii, bit-serial multipliers
// sequence: an input transfer starts the 16-step x pass (S_MULX), then S_YSUM, then the
//   STATE_WIDTH-step feedback pass (S_MULY), then S_UPD registers the result and goes idle;
//   a stalled result holds S_UPD, and the input stalls until idle, so one sample is in flight
// reset: coefficients return to the 90 Hz / 16 kHz set, both delay states clear,
//   the result register empties; no clearing pass
module biquad_highpass_filter
    import bq_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 30,
    parameter int STATE_WIDTH    = 56
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  in_item_t                  item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output out_item_t                 result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic signed [COEF_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(STATE_WIDTH);
    localparam int XP_W  = COEF_W + 1 + SAMPLE_W;
    localparam int FY_W  = STATE_WIDTH + COEF_W + 1 - COEF_FRAC_BITS;
    localparam int YS_W  = ((PX_W > STATE_WIDTH) ? PX_W : STATE_WIDTH) + 1;
    localparam int T_W   = ((YS_W > FY_W) ? YS_W : FY_W) + 1;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MULX = 3'd1;
    localparam logic [2:0] S_YSUM = 3'd2;
    localparam logic [2:0] S_MULY = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic signed [COEF_W-1:0]      coef_b0_reg, coef_b0_next;
    logic signed [COEF_W-1:0]      coef_b1_reg, coef_b1_next;
    logic signed [COEF_W-1:0]      coef_b2_reg, coef_b2_next;
    logic signed [COEF_W-1:0]      coef_a1_reg, coef_a1_next;
    logic signed [COEF_W-1:0]      coef_a2_reg, coef_a2_next;
    logic signed [STATE_WIDTH-1:0] d1_reg, d1_next;
    logic signed [STATE_WIDTH-1:0] d2_reg, d2_next;
    logic signed [STATE_WIDTH-1:0] y_reg, y_next;
    logic [STATE_WIDTH-1:0]        mult_sr_reg, mult_sr_next;
    logic signed [YS_W-1:0]        pd_reg, pd_next;
    logic signed [PX_W-1:0]        px2_reg, px2_next;
    out_item_t                     result_reg, result_next;
    logic                          result_valid_reg, result_valid_next;

    logic                          accept;
    logic                          last_step;
    mul_ctrl_t                     ctrl;
    logic signed [COEF_W-1:0]      mcand0, mcand1;
    logic signed [COEF_W:0]        acc0, acc1, acc2;
    logic [STATE_WIDTH-1:0]        low0, low1, low2;
    logic signed [XP_W-1:0]        xprod0, xprod1, xprod2;
    logic signed [PX_W-1:0]        px0, px1, px2;
    logic signed [FY_W-1:0]        fy1, fy2;
    logic signed [YS_W-1:0]        y_sum, pd_sum;
    logic signed [STATE_WIDTH-1:0] y_new, d1_new, d2_new;
    out_item_t                     rounded_item;

    // clamp a wide sum to the state width
    function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [T_W-1:0] v);
        logic [T_W-STATE_WIDTH:0]      top_bits;
        logic signed [STATE_WIDTH-1:0] res;
        top_bits = v[T_W-1:STATE_WIDTH-1];
        priority if ((&top_bits) || !(|top_bits))
        begin
            res = v[STATE_WIDTH-1:0];
        end
        else if (v[T_W-1])
        begin
            res = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // handshakes
    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // multiplier step control
    assign last_step = ((state_reg == S_MULX) && (cnt_reg == CNT_W'(SAMPLE_W - 1))) ||
                       ((state_reg == S_MULY) && (cnt_reg == CNT_W'(STATE_WIDTH - 1)));

    always_comb
    begin
        ctrl.clr    = accept || (state_reg == S_YSUM);
        ctrl.en     = (state_reg == S_MULX) || (state_reg == S_MULY);
        ctrl.mbit   = mult_sr_reg[0];
        ctrl.mlast  = last_step;
        ctrl.negate = (state_reg == S_MULY);
    end

    // units 0 and 1 take the feedforward then the feedback coefficient
    assign mcand0 = (state_reg == S_MULY) ? coef_a1_reg : coef_b0_reg;
    assign mcand1 = (state_reg == S_MULY) ? coef_a2_reg : coef_b1_reg;

    bq_serial_mul #(.LOW_W(STATE_WIDTH)) u_mul0
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .mcand (mcand0),
        .acc   (acc0),
        .low   (low0)
    );

    bq_serial_mul #(.LOW_W(STATE_WIDTH)) u_mul1
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .mcand (mcand1),
        .acc   (acc1),
        .low   (low1)
    );

    bq_serial_mul #(.LOW_W(STATE_WIDTH)) u_mul2
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .mcand (coef_b2_reg),
        .acc   (acc2),
        .low   (low2)
    );

    // products: x terms keep every bit, feedback terms drop the low fraction bits (floor)
    assign xprod0 = {acc0, low0[STATE_WIDTH-1 -: SAMPLE_W]};
    assign xprod1 = {acc1, low1[STATE_WIDTH-1 -: SAMPLE_W]};
    assign xprod2 = {acc2, low2[STATE_WIDTH-1 -: SAMPLE_W]};
    assign px0    = xprod0[PX_W-1:0];
    assign px1    = xprod1[PX_W-1:0];
    assign px2    = xprod2[PX_W-1:0];
    assign fy1    = {acc0, low0[STATE_WIDTH-1:COEF_FRAC_BITS]};
    assign fy2    = {acc1, low1[STATE_WIDTH-1:COEF_FRAC_BITS]};

    // sums with saturation
    assign y_sum  = YS_W'(px0) + YS_W'(d1_reg);
    assign pd_sum = YS_W'(px1) + YS_W'(d2_reg);
    assign y_new  = sat_state(T_W'(y_sum));
    assign d1_new = sat_state(T_W'(pd_reg) + T_W'(fy1));
    assign d2_new = sat_state(T_W'(px2_reg) + T_W'(fy2));

    bq_round_sat #(.STATE_W(STATE_WIDTH), .FRAC_W(COEF_FRAC_BITS)) u_round
    (
        .y      (y_reg),
        .result (rounded_item)
    );

    // configuration writes, unknown indexes ignored
    always_comb
    begin
        coef_b0_next = coef_b0_reg;
        coef_b1_next = coef_b1_reg;
        coef_b2_next = coef_b2_reg;
        coef_a1_next = coef_a1_reg;
        coef_a2_next = coef_a2_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_B0:  coef_b0_next = cfg_data;
                REG_B1:  coef_b1_next = cfg_data;
                REG_B2:  coef_b2_next = cfg_data;
                REG_A1:  coef_a1_next = cfg_data;
                REG_A2:  coef_a2_next = cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        d1_next           = d1_reg;
        d2_next           = d2_reg;
        y_next            = y_reg;
        mult_sr_next      = mult_sr_reg;
        pd_next           = pd_reg;
        px2_next          = px2_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next   = S_MULX;
                    cnt_next     = '0;
                    mult_sr_next = STATE_WIDTH'(item.sample_in);
                    if (item.restart)
                    begin
                        d1_next = '0;
                        d2_next = '0;
                    end
                end
            end
            S_MULX:
            begin
                mult_sr_next = mult_sr_reg >> 1;
                cnt_next     = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_YSUM;
                end
            end
            S_YSUM:
            begin
                y_next       = y_new;
                mult_sr_next = y_new;
                pd_next      = pd_sum;
                px2_next     = px2;
                cnt_next     = '0;
                state_next   = S_MULY;
            end
            S_MULY:
            begin
                mult_sr_next = mult_sr_reg >> 1;
                cnt_next     = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    d1_next           = d1_new;
                    d2_next           = d2_new;
                    result_next       = rounded_item;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            coef_b0_reg      <= B0_RESET;
            coef_b1_reg      <= B1_RESET;
            coef_b2_reg      <= B2_RESET;
            coef_a1_reg      <= A1_RESET;
            coef_a2_reg      <= A2_RESET;
            d1_reg           <= '0;
            d2_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            coef_b0_reg      <= coef_b0_next;
            coef_b1_reg      <= coef_b1_next;
            coef_b2_reg      <= coef_b2_next;
            coef_a1_reg      <= coef_a1_next;
            coef_a2_reg      <= coef_a2_next;
            d1_reg           <= d1_next;
            d2_reg           <= d2_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        y_reg       <= y_next;
        mult_sr_reg <= mult_sr_next;
        pd_reg      <= pd_next;
        px2_reg     <= px2_next;
        result_reg  <= result_next;
    end

endmodule

### hdl/bq_checker.sv
// port-level checks for the biquad high-pass filter, bound to the top level
// depends on bq_pkg and assert_macros.svh
`include "assert_macros.svh"

module bq_checker
    import bq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    logic in_xfer;
    logic on_rail;

    // input transfer and output rail flags
    assign in_xfer = item_valid && !item_stall;
    assign on_rail = (result.sample_out == 16'sh7fff) || (result.sample_out == 16'sh8000);

    // one sample in flight: a transfer closes the input channel
    `BQ_ASSERT_NXT(busy_after_transfer, in_xfer, item_stall, "input open after transfer")

    // the serial passes lie between transfer and result, so no result straight after a transfer
    `BQ_ASSERT_NXT(no_early_result, in_xfer, !$rose(result_valid), "result too early")

    // a clipped sample sits on one of the rails
    `BQ_ASSERT_IMP(clip_on_rail, result_valid && result.clipped, on_rail, "clip off the rails")

    // a stalled result stays offered
    `BQ_ASSERT_NXT(result_held, result_valid && result_stall, result_valid, "stalled result dropped")

endmodule

bind biquad_highpass_filter bq_checker u_bq_checker (.*);

### test/tb_biquad_highpass_filter.sv
// testbench for biquad_highpass_filter: a directed table, then random samples
// under changing coefficient sets, checked against a bit-exact predictor
// depends on bq_pkg and the biquad_highpass_filter rtl
`timescale 1ns / 100ps

module tb_biquad_highpass_filter;
    import bq_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int FRAC            = 30;
    localparam int STATE_W         = 56;
    localparam int NUM_COEFS       = 5;
    localparam int SETTLE_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SEGMENTS        = 8;
    localparam int SEG_ITEMS       = 125;
    localparam int PAUSE_AT        = 60;

    // register indexes past the coefficient file, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN  = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sh4000_0000;
    localparam logic signed [COEF_W-1:0] COEF_HALF = 32'sh2000_0000;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sh0000_0000;
    localparam int SMP_MAX = 32767;
    localparam int SMP_MIN = -32768;

    localparam logic signed [COEF_W-1:0] RESET_SET [NUM_COEFS] =
        '{B0_RESET, B1_RESET, B2_RESET, A1_RESET, A2_RESET};

    typedef logic signed [127:0] acc_t;
    localparam acc_t STATE_MAX = (acc_t'(1) <<< (STATE_W - 1)) - acc_t'(1);
    localparam acc_t STATE_MIN = -STATE_MAX - acc_t'(1);

    typedef enum logic {ROW_ITEM, ROW_COEF} row_kind_e;
    typedef enum int {SET_RESET, SET_MILD, SET_WILD, SET_CORNER} coef_set_e;

    typedef struct {
        row_kind_e                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic signed [COEF_W-1:0]  data;
        in_item_t                  smp;
        bit                        typed;
        out_item_t                 want;
    } row_t;

    // dut ports
    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    in_item_t                  item         = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    out_item_t                 result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index    = '0;
    logic signed [COEF_W-1:0]  cfg_data     = '0;

    // predictor state and coefficient copy
    logic signed [COEF_W-1:0]  coef_q [NUM_COEFS];
    acc_t                      z1_state;
    acc_t                      z2_state;
    out_item_t                 filtered_q [$];

    // typed expectation travelling with the current directed row
    bit                        fixed_want_en = 1'b0;
    out_item_t                 fixed_want    = '0;

    int src_idle = 0;
    int dst_idle = 0;
    int n_in, n_out, n_clipped, n_restart, n_cfg, n_sets, n_errors, idle_cycles;
    row_t table_rows [$];

    biquad_highpass_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // saturate to the signed state width
    function automatic acc_t clamp_state(acc_t v);
        if (v > STATE_MAX)
            return STATE_MAX;
        if (v < STATE_MIN)
            return STATE_MIN;
        return v;
    endfunction

    // one filter step: optional restart clear, output, then both delay states, then round and clip
    function automatic out_item_t filter_step(in_item_t smp);
        acc_t x, y, mag, q, b0, b1, b2, a1, a2;
        bit clip;
        out_item_t r;
        x  = acc_t'(smp.sample_in);
        b0 = acc_t'(coef_q[REG_B0]);
        b1 = acc_t'(coef_q[REG_B1]);
        b2 = acc_t'(coef_q[REG_B2]);
        a1 = acc_t'(coef_q[REG_A1]);
        a2 = acc_t'(coef_q[REG_A2]);
        clip = 1'b0;
        if (smp.restart)
        begin
            z1_state = '0;
            z2_state = '0;
        end
        y = clamp_state(x * b0 + z1_state);
        z1_state = clamp_state(x * b1 + z2_state + ((y * -a1) >>> FRAC));
        z2_state = clamp_state(x * b2 + ((y * -a2) >>> FRAC));
        // round half away from zero on the magnitude
        mag = (y < 0) ? -y : y;
        q = (mag >>> FRAC) + acc_t'(mag[FRAC-1]);
        if (y < 0)
        begin
            if (q > 32768)
            begin
                q = 32768;
                clip = 1'b1;
            end
            q = -q;
        end
        else if (q > 32767)
        begin
            q = 32767;
            clip = 1'b1;
        end
        r.sample_out = q[SAMPLE_W-1:0];
        r.clipped = clip;
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        n_errors++;
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 field, n_out, got, want);
    endtask

    // table row builders
    function automatic row_t coef_row(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] data);
        row_t r;
        r = '{kind: ROW_COEF, idx: idx, data: data, smp: '0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic row_t item_row(int s, bit rst);
        row_t r;
        r = '{kind: ROW_ITEM, idx: '0, data: '0, smp: '0, typed: 1'b0, want: '0};
        r.smp.sample_in = s[SAMPLE_W-1:0];
        r.smp.restart = rst;
        return r;
    endfunction

    function automatic row_t typed_row(int s, bit rst, int want_s, bit want_clip);
        row_t r;
        r = item_row(s, rst);
        r.typed = 1'b1;
        r.want.sample_out = want_s[SAMPLE_W-1:0];
        r.want.clipped = want_clip;
        return r;
    endfunction

    // one sample transfer, with random idle cycles ahead of it
    task automatic send_sample(in_item_t smp, bit typed, out_item_t want);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item          <= smp;
        item_valid    <= 1'b1;
        fixed_want_en <= typed;
        fixed_want    <= want;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // stop sending and wait until every pending result has come back
    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= REG_A2)
            coef_q[idx] = val;
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // write a whole coefficient set, sometimes with a dropped spare write first
    task automatic load_coefs(coef_set_e mode);
        logic signed [COEF_W-1:0] val;
        wait_drained();
        n_sets++;
        if ($urandom_range(1))
            write_coef(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), $urandom);
        for (int r = 0; r < NUM_COEFS; r++)
        begin
            case (mode)
                SET_RESET:
                    val = RESET_SET[r];
                SET_MILD:
                    val = (r >= REG_A1) ? RESET_SET[r]
                                        : $urandom_range(32'h7FFF_FFFF, 0) - 32'h4000_0000;
                SET_WILD:
                    val = $urandom;
                default:
                    case ($urandom_range(3))
                        0:       val = COEF_MAX;
                        1:       val = COEF_MIN;
                        2:       val = COEF_ZERO;
                        default: val = COEF_ONE;
                    endcase
            endcase
            write_coef(CFG_IDX_W'(r), val);
        end
    endtask

    // random sample: some extremes, some quiet signal, mostly full range
    function automatic in_item_t rand_sample();
        in_item_t smp;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            case ($urandom_range(4))
                0:       smp.sample_in = SMP_MAX[SAMPLE_W-1:0];
                1:       smp.sample_in = SMP_MIN[SAMPLE_W-1:0];
                2:       smp.sample_in = '0;
                3:       smp.sample_in = 16'sd1;
                default: smp.sample_in = -16'sd1;
            endcase
        end
        else if (pick < 40)
            smp.sample_in = SAMPLE_W'(int'($urandom_range(511)) - 256);
        else
            smp.sample_in = SAMPLE_W'($urandom);
        smp.restart = ($urandom_range(99) < 3);
        return smp;
    endfunction

    // receiver back-pressure
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < dst_idle);

    // transfer monitor: result check, prediction, watchdog
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t pred;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                moved = 1'b1;
                n_out++;
                if (filtered_q.size() == 0)
                    report_mismatch("result with nothing pending", result.sample_out, 0);
                else
                begin
                    want = filtered_q.pop_front();
                    if (result.sample_out !== want.sample_out)
                        report_mismatch("sample_out", result.sample_out, want.sample_out);
                    if (result.clipped !== want.clipped)
                        report_mismatch("clipped", result.clipped, want.clipped);
                    if (want.clipped)
                        n_clipped++;
                end
            end
            if (item_valid && !item_stall)
            begin
                moved = 1'b1;
                pred = filter_step(item);
                filtered_q.push_back(fixed_want_en ? fixed_want : pred);
                n_in++;
                if (item.restart)
                    n_restart++;
            end
            if (cfg_valid && cfg_ready)
                moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transfer, %0d results pending",
                     idle_cycles, filtered_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        in_item_t smp;
        foreach (coef_q[i])
            coef_q[i] = RESET_SET[i];
        z1_state = '0;
        z2_state = '0;

        // directed table
        // reset coefficients: quiet start, full-scale steps, restart mid-stream
        table_rows.push_back(typed_row(0, 1'b0, 0, 1'b0));
        table_rows.push_back(item_row(SMP_MAX, 1'b0));
        table_rows.push_back(item_row(SMP_MIN, 1'b0));
        table_rows.push_back(item_row(SMP_MAX, 1'b0));
        table_rows.push_back(item_row(SMP_MIN, 1'b0));
        table_rows.push_back(item_row(1000, 1'b1));
        // unity pass-through
        table_rows.push_back(coef_row(REG_B0, COEF_ONE));
        table_rows.push_back(coef_row(REG_B1, COEF_ZERO));
        table_rows.push_back(coef_row(REG_B2, COEF_ZERO));
        table_rows.push_back(coef_row(REG_A1, COEF_ZERO));
        table_rows.push_back(coef_row(REG_A2, COEF_ZERO));
        table_rows.push_back(typed_row(SMP_MAX, 1'b1, SMP_MAX, 1'b0));
        table_rows.push_back(typed_row(SMP_MIN, 1'b0, SMP_MIN, 1'b0));
        table_rows.push_back(typed_row(-1, 1'b0, -1, 1'b0));
        // half gain gives exact ties; spare indexes must change nothing
        table_rows.push_back(coef_row(REG_B0, COEF_HALF));
        table_rows.push_back(coef_row(REG_SPARE_FIRST, COEF_MAX));
        table_rows.push_back(coef_row(REG_SPARE_LAST, COEF_MIN));
        table_rows.push_back(typed_row(1, 1'b0, 1, 1'b0));
        table_rows.push_back(typed_row(-1, 1'b0, -1, 1'b0));
        table_rows.push_back(typed_row(3, 1'b0, 2, 1'b0));
        table_rows.push_back(typed_row(-3, 1'b0, -2, 1'b0));
        // largest gain, output clips both ways
        table_rows.push_back(coef_row(REG_B0, COEF_MAX));
        table_rows.push_back(typed_row(16384, 1'b0, SMP_MAX, 1'b1));
        table_rows.push_back(typed_row(SMP_MIN, 1'b0, SMP_MIN, 1'b1));
        table_rows.push_back(typed_row(SMP_MAX, 1'b0, SMP_MAX, 1'b1));
        // most negative gain
        table_rows.push_back(coef_row(REG_B0, COEF_MIN));
        table_rows.push_back(typed_row(SMP_MIN, 1'b0, SMP_MAX, 1'b1));
        table_rows.push_back(typed_row(SMP_MAX, 1'b0, SMP_MIN, 1'b1));
        // unstable extremes, delay states run into saturation
        table_rows.push_back(coef_row(REG_B0, COEF_MAX));
        table_rows.push_back(coef_row(REG_B1, COEF_MIN));
        table_rows.push_back(coef_row(REG_B2, COEF_MAX));
        table_rows.push_back(coef_row(REG_A1, COEF_MIN));
        table_rows.push_back(coef_row(REG_A2, COEF_MAX));
        for (int i = 0; i < 5; i++)
            table_rows.push_back(item_row((i % 2) ? SMP_MIN : SMP_MAX, 1'b0));
        table_rows.push_back(coef_row(REG_B1, COEF_MAX));
        table_rows.push_back(coef_row(REG_A1, COEF_MAX));
        table_rows.push_back(coef_row(REG_A2, COEF_MIN));
        table_rows.push_back(item_row(SMP_MIN, 1'b0));
        table_rows.push_back(item_row(SMP_MAX, 1'b0));

        // reset
        src_idle = 19;
        dst_idle = 88;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
        begin
            if (table_rows[i].kind == ROW_COEF)
            begin
                wait_drained();
                write_coef(table_rows[i].idx, table_rows[i].data);
            end
            else
                send_sample(table_rows[i].smp, table_rows[i].typed, table_rows[i].want);
        end

        // random part: each segment loads a coefficient set and takes the idling mix of its third of the run
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg * 3 / SEGMENTS)
                0:
                begin
                    src_idle = 19;
                    dst_idle = 88;
                end
                1:
                begin
                    src_idle = 88;
                    dst_idle = 19;
                end
                default:
                begin
                    src_idle = 0;
                    dst_idle = 0;
                end
            endcase
            load_coefs(coef_set_e'(seg % 4));
            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                if (i == PAUSE_AT)
                    wait_drained();
                smp = rand_sample();
                send_sample(smp, 1'b0, '0);
            end
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d samples (%0d with restart) over %0d coefficient sets, %0d writes",
                 n_in, n_restart, n_sets, n_cfg);
        $display("checked %0d results, %0d clipped, %0d mismatches",
                 n_out, n_clipped, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
